/* rtl/bom_pkg.sv */
// Shared types, widths and register codes for the broadcast offset mapper.
// No dependencies; every other file in rtl/ imports this package.
package bom_pkg;

  // Field widths
  localparam int OFS_W     = 32;  // linear offsets
  localparam int DIM_W     = 16;  // dimension sizes
  localparam int MAX_DIMS  = 4;   // dimension positions of both tensors
  localparam int REG_DIMS  = 4;   // dimension registers per tensor
  localparam int REG_IDX_W = $clog2(REG_DIMS);
  localparam int CFG_IDX_W = $clog2(2 * REG_DIMS);

  // One lane: a divide-step cell per offset bit, a modulo-step cell per
  // dimension bit, then one multiply-accumulate register.
  localparam int DIV_CELLS = OFS_W;
  localparam int MOD_CELLS = DIM_W;
  localparam int LANE_CELLS = DIV_CELLS + MOD_CELLS;
  localparam int LANE_LAT  = LANE_CELLS + 1;
  localparam int PIPE_LAT  = MAX_DIMS * LANE_LAT;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIM0  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIM1  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIM2  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIM3  = CFG_IDX_W'(7);

  typedef logic [REG_DIMS-1:0][DIM_W-1:0] dims_t;

  // Beat handed from lane to lane
  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] rest;  // offset still to be split
    logic [OFS_W-1:0] acc;   // input offset so far
  } beat_t;

  // Beat handed from cell to cell inside a lane
  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] rem;   // partial remainder
    logic [OFS_W-1:0] quo;   // dividend bits in, quotient bits out
    logic [OFS_W-1:0] keep;  // quotient parked during the modulo steps
    logic [OFS_W-1:0] acc;
  } cell_t;

  // Size of dimension position p (0 = outermost); zero reads as one,
  // positions with no register are one.
  function automatic logic [DIM_W-1:0] dim_at(dims_t regs, int p);
    int r;
    logic [DIM_W-1:0] v;
    r = p - (MAX_DIMS - REG_DIMS);
    v = DIM_W'(1);
    if (r >= 0 && r < REG_DIMS) begin
      v = regs[REG_IDX_W'(r)];
      if (v == '0) v = DIM_W'(1);
    end
    return v;
  endfunction

endpackage

/* rtl/broadcast_offset_mapper_unit.sv */
// Top level of the broadcast offset mapper: dimension registers, stride
// chain and one lane per dimension position. Depends on bom_pkg, bom_lane.
//
//  channel   ports                              beat taken when
//  ------    ---------------------------------  ------------------------
//  command   start, busy, out_offset            start high, busy low
//  result    done, in_offset                    every cycle done is high
//  config    cfg_we, cfg_idx, cfg_data          cfg_we high
//
// One offset is taken every cycle; busy is never raised.
// Per dimension the pipe holds one division cell per offset bit, one per
// dimension bit and one MAC register.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Synchronous reset empties the pipe and sets every dimension to one.
// Strides settle through the registered multiply chain after a dimension write.
module broadcast_offset_mapper_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bom_pkg::OFS_W-1:0]     out_offset,
  output logic                          done,
  output logic [bom_pkg::OFS_W-1:0]     in_offset,
  input  logic                          cfg_we,
  input  logic [bom_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bom_pkg::DIM_W-1:0]     cfg_data
);
  import bom_pkg::*;

  dims_t            out_dims;
  dims_t            in_dims;
  logic [DIM_W-1:0] od_eff [MAX_DIMS];
  logic [DIM_W-1:0] id_eff [MAX_DIMS];
  logic [OFS_W-1:0] stride [MAX_DIMS];
  beat_t            beats  [0:MAX_DIMS];
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_DIMS; i++) begin
        out_dims[i] <= DIM_W'(1);
        in_dims[i]  <= DIM_W'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OUT_DIM0: out_dims[0] <= cfg_data;
        REG_OUT_DIM1: out_dims[1] <= cfg_data;
        REG_OUT_DIM2: out_dims[2] <= cfg_data;
        REG_OUT_DIM3: out_dims[3] <= cfg_data;
        REG_IN_DIM0:  in_dims[0]  <= cfg_data;
        REG_IN_DIM1:  in_dims[1]  <= cfg_data;
        REG_IN_DIM2:  in_dims[2]  <= cfg_data;
        REG_IN_DIM3:  in_dims[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // lane g serves position MAX_DIMS-1-g, innermost first
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
    assign od_eff[g] = dim_at(out_dims, MAX_DIMS - 1 - g);
    assign id_eff[g] = dim_at(in_dims, MAX_DIMS - 1 - g);
  end

  // row-major strides, one registered multiply per step
  assign stride[0] = OFS_W'(1);
  for (genvar g = 1; g < MAX_DIMS; g++) begin : g_stride
    logic [OFS_W+DIM_W-1:0] stride_prod;
    assign stride_prod = stride[g-1] * id_eff[g-1];
    always_ff @(posedge clk) begin
      stride[g] <= stride_prod[OFS_W-1:0];
    end
  end

  // command beat into the first lane
  always_comb begin
    beats[0].valid = accept;
    beats[0].rest  = out_offset;
    beats[0].acc   = '0;
  end

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
    bom_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (beats[g]),
      .out_dim  (od_eff[g]),
      .in_dim   (id_eff[g]),
      .stride   (stride[g]),
      .beat_out (beats[g+1])
    );
  end

  assign done      = beats[MAX_DIMS].valid;
  assign in_offset = beats[MAX_DIMS].acc;

  // a result only ever comes from an earlier accepted command
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && !rst, PIPE_LAT))
    else $error("result strobe without matching command");

  // the outermost stride follows its neighbour in the next cycle
  if (MAX_DIMS > 1) begin : g_chk_stride
    a_stride_chain: assert property (@(posedge clk) disable iff (rst)
      $past(!rst) |-> stride[MAX_DIMS-1] ==
        OFS_W'($past(stride[MAX_DIMS-2]) * $past(id_eff[MAX_DIMS-2])))
      else $error("stride chain out of step");
  end

endmodule

/* rtl/bom_div_cell.sv */
// One restoring division step: shifts a dividend bit into the remainder and
// emits one quotient bit. Depends on bom_pkg.
module bom_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  bom_pkg::cell_t          cell_in,
  input  logic [bom_pkg::DIM_W-1:0] divisor,
  output bom_pkg::cell_t          cell_out
);
  import bom_pkg::*;

  logic [DIM_W:0] trial;
  logic [DIM_W:0] diff;
  logic           take;

  // trial subtract
  always_comb begin
    trial = {cell_in.rem, cell_in.quo[OFS_W-1]};
    diff  = trial - {1'b0, divisor};
    take  = trial >= {1'b0, divisor};
  end

  // step register; valid is the only control bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.rem  <= take ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    cell_out.quo  <= {cell_in.quo[OFS_W-2:0], take};
    cell_out.keep <= cell_in.keep;
    cell_out.acc  <= cell_in.acc;
  end

endmodule

/* rtl/bom_lane.sv */
// One dimension of the mapping: a row of division cells for rest / out_dim,
// a row for index % in_dim, then index * stride accumulate.
// Depends on bom_pkg and bom_div_cell.
module bom_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  bom_pkg::beat_t          beat_in,
  input  logic [bom_pkg::DIM_W-1:0] out_dim,
  input  logic [bom_pkg::DIM_W-1:0] in_dim,
  input  logic [bom_pkg::OFS_W-1:0] stride,
  output bom_pkg::beat_t          beat_out
);
  import bom_pkg::*;

  cell_t            chain [0:LANE_CELLS];
  cell_t            mod_load;
  logic [OFS_W+DIM_W-1:0] prod;

  // load the offset as dividend, remainder clear
  always_comb begin
    chain[0].valid = beat_in.valid;
    chain[0].rem   = '0;
    chain[0].quo   = beat_in.rest;
    chain[0].keep  = '0;
    chain[0].acc   = beat_in.acc;
  end

  // after the divide: park the quotient, feed the remainder as new dividend
  always_comb begin
    mod_load.valid = chain[DIV_CELLS].valid;
    mod_load.rem   = '0;
    mod_load.quo   = {chain[DIV_CELLS].rem, (OFS_W-DIM_W)'(0)};
    mod_load.keep  = chain[DIV_CELLS].quo;
    mod_load.acc   = chain[DIV_CELLS].acc;
  end

  for (genvar i = 0; i < LANE_CELLS; i++) begin : g_cell
    if (i < DIV_CELLS) begin : g_div
      bom_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_in  (chain[i]),
        .divisor  (out_dim),
        .cell_out (chain[i+1])
      );
    end else if (i == DIV_CELLS) begin : g_first_mod
      bom_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_in  (mod_load),
        .divisor  (in_dim),
        .cell_out (chain[i+1])
      );
    end else begin : g_mod
      bom_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_in  (chain[i]),
        .divisor  (in_dim),
        .cell_out (chain[i+1])
      );
    end
  end

  // index * stride, mod 2^32
  assign prod = chain[LANE_CELLS].rem * stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= chain[LANE_CELLS].valid;
    end
    beat_out.rest <= chain[LANE_CELLS].keep;
    beat_out.acc  <= chain[LANE_CELLS].acc + prod[OFS_W-1:0];
  end

endmodule
